FILE: rtl/path_lookahead_point_finder_top_macros.svh
// Assertion helpers for the look-ahead point finder.
`ifndef PATH_LOOKAHEAD_POINT_FINDER_TOP_MACROS_SVH
`define PATH_LOOKAHEAD_POINT_FINDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PLPF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plpf check failed");
`define PLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plpf check failed");
`else
`define PLPF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PLPF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/plpf_pkg.sv
`default_nettype none
package plpf_pkg;
   localparam int PATH_DEPTH_DEF = 256;
   localparam logic [30:0] RADIUS_RESET = 31'd786432;
   localparam logic [3:0] BISECT_LAST = 4'd9;
   localparam logic [10:0] T_ONE = 11'd1024;
   localparam int T_SHIFT = 10;
   localparam int DIST_W = 65;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] SRC_END     = 2'd0;
   localparam logic [1:0] SRC_INTERP  = 2'd1;
   localparam logic [1:0] SRC_NEAREST = 2'd2;
   localparam logic [1:0] SRC_EMPTY   = 2'd3;

   localparam logic CSR_RADIUS = 1'b0;

   typedef struct packed {
      logic valid;
      logic last;
      logic bis;
   } dist_ctl_type;
endpackage
`default_nettype wire

FILE: rtl/plpf_ram.sv
`default_nettype none
module plpf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: rtl/plpf_dist.sv
`default_nettype none
module plpf_dist
   import plpf_pkg::*;
#(
   parameter int IW = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dist_ctl_type        i_ctl,
   input  wire logic [IW-1:0]       i_idx,
   input  wire logic signed [31:0]  i_ax,
   input  wire logic signed [31:0]  i_ay,
   input  wire logic signed [31:0]  i_bx,
   input  wire logic signed [31:0]  i_by,
   output dist_ctl_type             o_ctl,
   output logic [IW-1:0]            o_idx,
   output logic signed [31:0]       o_ax,
   output logic signed [31:0]       o_ay,
   output logic [DIST_W-1:0]        o_d
);
   dist_ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic [IW-1:0] idx1_ff, idx2_ff, idx3_ff;
   logic signed [31:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic [31:0] ux_ff, uy_ff;
   logic [63:0] sx_ff, sy_ff;
   logic [DIST_W-1:0] d_ff;
   logic signed [32:0] dx_in, dy_in;
   logic [32:0] ax_abs, ay_abs;

   always_comb begin
      dx_in  = {i_ax[31], i_ax} - {i_bx[31], i_bx};
      dy_in  = {i_ay[31], i_ay} - {i_by[31], i_by};
      ax_abs = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
      ay_abs = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl1_ff <= i_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
      idx1_ff <= i_idx;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      ax1_ff  <= i_ax;
      ay1_ff  <= i_ay;
      ax2_ff  <= ax1_ff;
      ay2_ff  <= ay1_ff;
      ax3_ff  <= ax2_ff;
      ay3_ff  <= ay2_ff;
      ux_ff   <= ax_abs[31:0];
      uy_ff   <= ay_abs[31:0];
      sx_ff   <= ux_ff * ux_ff;
      sy_ff   <= uy_ff * uy_ff;
      d_ff    <= {1'b0, sx_ff} + {1'b0, sy_ff};
   end

   assign o_ctl = ctl3_ff;
   assign o_idx = idx3_ff;
   assign o_ax  = ax3_ff;
   assign o_ay  = ay3_ff;
   assign o_d   = d_ff;
endmodule
`default_nettype wire

FILE: rtl/path_lookahead_point_finder_top.sv
// Look-ahead point finder: holds a waypoint path and answers look-ahead
// requests for a robot position.
// Request channel: a request is taken when start is high and busy is low.
// req_kind selects clear (path emptied), append (waypoint stored unless the
// path is full) or query. Clear and append finish in the accepting cycle and
// give no response; busy stays low. A query on an empty path answers in the
// next cycle with source "path empty".
// Any other query raises busy until its single response is out: rsp_valid
// is high for exactly one cycle with the point, nearest index and source.
// The receiver cannot stall; rsp_valid simply pulses.
// A query runs the radius and end-point test, then a nearest-waypoint pass
// and, when a segment lies past the nearest waypoint, a segment pass, all
// bound by the single read port of the waypoint memory (one entry per cycle)
// feeding a 3-stage squared-distance pipeline; an interpolated answer adds
// ten bisection steps.
// Radius register at byte 0 of the csr port, reset 12.0 (Q16.16).
// Reset empties the path and restores the radius; memory is not cleared.
`default_nettype none
`include "path_lookahead_point_finder_top_macros.svh"
module path_lookahead_point_finder_top
   import plpf_pkg::*;
#(
   parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_point_x,
   output logic signed [31:0]      rsp_point_y,
   output logic [7:0]              rsp_nearest_index,
   output logic [1:0]              rsp_source,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   localparam int IW = $clog2(PATH_DEPTH);
   localparam int CW = $clog2(PATH_DEPTH + 1);
   localparam int NW = CW + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_END, ST_NEAR, ST_SEG, ST_BIS_MUL, ST_BIS_ADD, ST_BIS_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [30:0] radius_ff;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [DIST_W-1:0] r2_ff, r2_in, best_ff, best_in, prev_d_ff, prev_d_in;
   logic got_r2_ff, got_r2_in, seg_first_ff, seg_first_in;
   logic [IW-1:0] near_ff, near_in;
   logic signed [31:0] near_x_ff, near_x_in, near_y_ff, near_y_in;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, nx_ff, nx_in, ny_ff, ny_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [44:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [10:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [3:0] step_ff, step_in;
   logic [IW-1:0] ptr_ff, ptr_in, end_ff, end_in, rd_idx_ff;
   logic issuing_ff, issuing_in, rd_v_ff, rd_last_ff;
   logic rsp_valid_in;
   logic signed [31:0] rsp_x_in, rsp_y_in;
   logic [IW-1:0] rsp_idx_ff, rsp_idx_in;
   logic [1:0] rsp_src_in;

   logic accept, csr_wr, mem_we;
   logic [63:0] mem_rdata;
   logic [IW-1:0] last_idx;
   dist_ctl_type d_ictl, d_octl;
   logic [IW-1:0] d_iidx, d_oidx;
   logic signed [31:0] d_iax, d_iay, d_ibx, d_iby, d_oax, d_oay;
   logic [DIST_W-1:0] d_od;
   logic [IW-1:0] cand_near;
   logic [NW-1:0] seg_lim;
   logic [11:0] mid_sum;
   logic signed [34:0] fx, fy;
   logic [IW+7:0] idx_ext;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_RADIUS) ? {1'b0, radius_ff} : 32'd0;
   assign mem_we     = accept && (req_kind == KIND_APPEND) && (count_ff < CW'(PATH_DEPTH));
   assign last_idx   = IW'(count_ff - CW'(1));

   plpf_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path (
      .clock (clock),
      .we    (mem_we),
      .waddr (count_ff[IW-1:0]),
      .wdata ({req_pos_x, req_pos_y}),
      .raddr (ptr_ff),
      .rdata (mem_rdata)
   );

   // Feed the distance pipe: memory stream first, else radius or bisection point.
   always_comb begin
      d_ictl = '0;
      d_iidx = rd_idx_ff;
      d_iax  = $signed(mem_rdata[63:32]);
      d_iay  = $signed(mem_rdata[31:0]);
      d_ibx  = rx_ff;
      d_iby  = ry_ff;
      if (rd_v_ff) begin
         d_ictl.valid = 1'b1;
         d_ictl.last  = rd_last_ff;
      end else if (state_ff == ST_BIS_ADD) begin
         d_ictl.valid = 1'b1;
         d_ictl.last  = 1'b1;
         d_ictl.bis   = 1'b1;
         d_iax        = nx_in;
         d_iay        = ny_in;
      end else if (accept && (req_kind == KIND_QUERY) && (count_ff != '0)) begin
         // radius squared: distance of (r, 0) from the origin
         d_ictl.valid = 1'b1;
         d_ictl.last  = 1'b1;
         d_iax        = $signed({1'b0, radius_ff});
         d_iay        = '0;
         d_ibx        = '0;
         d_iby        = '0;
      end
   end

   plpf_dist #(.IW(IW)) u_dist (
      .clock (clock),
      .reset (reset),
      .i_ctl (d_ictl),
      .i_idx (d_iidx),
      .i_ax  (d_iax),
      .i_ay  (d_iay),
      .i_bx  (d_ibx),
      .i_by  (d_iby),
      .o_ctl (d_octl),
      .o_idx (d_oidx),
      .o_ax  (d_oax),
      .o_ay  (d_oay),
      .o_d   (d_od)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      r2_in        = r2_ff;
      got_r2_in    = got_r2_ff;
      best_in      = best_ff;
      near_in      = near_ff;
      near_x_in    = near_x_ff;
      near_y_in    = near_y_ff;
      prev_d_in    = prev_d_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      seg_first_in = seg_first_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      step_in      = step_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_point_x;
      rsp_y_in     = rsp_point_y;
      rsp_idx_in   = rsp_idx_ff;
      rsp_src_in   = rsp_source;
      // advance the read stream
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      issuing_in   = issuing_ff;
      if (issuing_ff) begin
         ptr_in = ptr_ff + IW'(1);
         if (ptr_ff == end_ff) begin
            issuing_in = 1'b0;
         end
      end

      cand_near = near_ff;
      if ((d_oidx == '0) || (d_od < best_ff)) begin
         cand_near = d_oidx;
      end
      seg_lim = NW'(cand_near) + NW'(2);

      mid_sum = 12'(lo_ff) + 12'(hi_ff);
      fx      = 35'(qx_ff >>> T_SHIFT);
      fy      = 35'(qy_ff >>> T_SHIFT);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_APPEND: begin
                     if (mem_we) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_QUERY: begin
                     rx_in = req_pos_x;
                     ry_in = req_pos_y;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_x_in     = '0;
                        rsp_y_in     = '0;
                        rsp_idx_in   = '0;
                        rsp_src_in   = SRC_EMPTY;
                     end else begin
                        // radius goes in now, last waypoint read right after
                        got_r2_in  = 1'b0;
                        ptr_in     = last_idx;
                        end_in     = last_idx;
                        issuing_in = 1'b1;
                        state_in   = ST_END;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_END: begin
            if (d_octl.valid && !d_octl.bis) begin
               if (!got_r2_ff) begin
                  r2_in     = d_od;
                  got_r2_in = 1'b1;
               end else if (d_od < r2_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = d_oax;
                  rsp_y_in     = d_oay;
                  rsp_idx_in   = '0;
                  rsp_src_in   = SRC_END;
                  state_in     = ST_IDLE;
               end else begin
                  ptr_in     = '0;
                  end_in     = last_idx;
                  issuing_in = 1'b1;
                  state_in   = ST_NEAR;
               end
            end
         end
         ST_NEAR: begin
            if (d_octl.valid && !d_octl.bis) begin
               if ((d_oidx == '0) || (d_od < best_ff)) begin
                  best_in   = d_od;
                  near_in   = d_oidx;
                  near_x_in = d_oax;
                  near_y_in = d_oay;
               end
               if (d_octl.last) begin
                  if (seg_lim < NW'(count_ff)) begin
                     ptr_in       = cand_near + IW'(1);
                     end_in       = last_idx;
                     issuing_in   = 1'b1;
                     seg_first_in = 1'b1;
                     state_in     = ST_SEG;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = ((d_oidx == '0) || (d_od < best_ff)) ? d_oax : near_x_ff;
                     rsp_y_in     = ((d_oidx == '0) || (d_od < best_ff)) ? d_oay : near_y_ff;
                     rsp_idx_in   = cand_near;
                     rsp_src_in   = SRC_NEAREST;
                     state_in     = ST_IDLE;
                  end
               end
            end
         end
         ST_SEG: begin
            if (d_octl.valid && !d_octl.bis) begin
               prev_d_in    = d_od;
               prev_x_in    = d_oax;
               prev_y_in    = d_oay;
               seg_first_in = 1'b0;
               if (!seg_first_ff && (r2_ff < prev_d_ff) && (d_od < r2_ff)) begin
                  // crossing found: bisect from this point back toward the previous one
                  px_in      = d_oax;
                  py_in      = d_oay;
                  dx_in      = {prev_x_ff[31], prev_x_ff} - {d_oax[31], d_oax};
                  dy_in      = {prev_y_ff[31], prev_y_ff} - {d_oay[31], d_oay};
                  lo_in      = '0;
                  hi_in      = T_ONE;
                  step_in    = '0;
                  issuing_in = 1'b0;
                  state_in   = ST_BIS_MUL;
               end else if (d_octl.last) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = near_x_ff;
                  rsp_y_in     = near_y_ff;
                  rsp_idx_in   = near_ff;
                  rsp_src_in   = SRC_NEAREST;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_BIS_MUL: begin
            mid_in   = mid_sum[11:1];
            qx_in    = dx_ff * $signed({1'b0, mid_sum[11:1]});
            qy_in    = dy_ff * $signed({1'b0, mid_sum[11:1]});
            state_in = ST_BIS_ADD;
         end
         ST_BIS_ADD: begin
            // floor of q / 1024 is an arithmetic shift
            nx_in    = 32'(35'(px_ff) + fx);
            ny_in    = 32'(35'(py_ff) + fy);
            state_in = ST_BIS_WAIT;
         end
         ST_BIS_WAIT: begin
            if (d_octl.valid && d_octl.bis) begin
               if (d_od < r2_ff) begin
                  lo_in = mid_ff;
               end else begin
                  hi_in = mid_ff;
               end
               step_in = step_ff + 4'd1;
               if (step_ff == BISECT_LAST) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = nx_ff;
                  rsp_y_in     = ny_ff;
                  rsp_idx_in   = near_ff;
                  rsp_src_in   = SRC_INTERP;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_BIS_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         radius_ff  <= RADIUS_RESET;
         issuing_ff <= 1'b0;
         rd_v_ff    <= 1'b0;
         rsp_valid  <= 1'b0;
         got_r2_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         issuing_ff <= issuing_in;
         rd_v_ff    <= issuing_ff;
         rsp_valid  <= rsp_valid_in;
         got_r2_ff  <= got_r2_in;
         if (csr_wr && (csr_paddr[2] == CSR_RADIUS)) begin
            radius_ff <= csr_pwdata[30:0];
         end
      end
      rd_idx_ff    <= ptr_ff;
      rd_last_ff   <= (ptr_ff == end_ff);
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      r2_ff        <= r2_in;
      best_ff      <= best_in;
      near_ff      <= near_in;
      near_x_ff    <= near_x_in;
      near_y_ff    <= near_y_in;
      prev_d_ff    <= prev_d_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      seg_first_ff <= seg_first_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      step_ff      <= step_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      rsp_point_x  <= rsp_x_in;
      rsp_point_y  <= rsp_y_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_source   <= rsp_src_in;
   end

   assign idx_ext           = {8'd0, rsp_idx_ff};
   assign rsp_nearest_index = idx_ext[7:0];

   // every query that raised busy ends with a response
   `PLPF_ASSERT_IMP(a_done_responds, clock, reset, $fell(busy), rsp_valid)
   // a query on a non-empty path holds the block busy
   `PLPF_ASSERT_NEXT(a_query_busy, clock, reset,
      accept && (req_kind == KIND_QUERY) && (count_ff != '0), busy)
   // the fill count never passes the store depth
   `PLPF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(PATH_DEPTH))
   // bisection answers only leave after the last step
   `PLPF_ASSERT_IMP(a_interp_steps, clock, reset,
      rsp_valid_in && (rsp_src_in == SRC_INTERP), step_ff == BISECT_LAST)
endmodule
`default_nettype wire

FILE: tb/path_lookahead_point_finder_checker.sv
`default_nettype none
module path_lookahead_point_finder_checker
   import plpf_pkg::*;
#(
   parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_point_x,
   input  wire logic signed [31:0] rsp_point_y,
   input  wire logic [7:0]         rsp_nearest_index,
   input  wire logic [1:0]         rsp_source,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   input  wire logic               csr_pready,
   output int                      pending,
   output int                      failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [7:0]         idx;
      logic [1:0]         src;
   } lookahead_type;

   logic signed [31:0] wp_x [PATH_DEPTH];
   logic signed [31:0] wp_y [PATH_DEPTH];
   int unsigned        wp_count;
   logic [30:0]        radius;
   lookahead_type      expected_points [$];

   // Exact squared distance; each square is below 2**64, so 65 bits hold the sum.
   function automatic logic [64:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] bx, logic signed [31:0] by);
      logic signed [32:0] dx, dy;
      logic [32:0] ux, uy;
      dx = 33'(ax) - 33'(bx);
      dy = 33'(ay) - 33'(by);
      ux = dx[32] ? -dx : dx;
      uy = dy[32] ? -dy : dy;
      return 65'(ux) * 65'(ux) + 65'(uy) * 65'(uy);
   endfunction

   // Floor of (to-from)*t/1024 added to from.
   function automatic logic signed [31:0] along(logic signed [31:0] from,
                                                logic signed [31:0] to, int t);
      longint q;
      q = (longint'(to) - longint'(from)) * t;
      return 32'(longint'(from) + (q >>> T_SHIFT));
   endfunction

   function automatic lookahead_type find_point(logic signed [31:0] rx,
                                                logic signed [31:0] ry);
      lookahead_type res;
      logic [64:0] r2, best, d, dc, dp;
      int n, near, lo, hi, mid;
      logic signed [31:0] nx, ny;
      n = wp_count;
      if (n == 0) begin
         res = '{0, 0, 8'd0, SRC_EMPTY};
         return res;
      end
      r2 = 65'(radius) * 65'(radius);
      if (sq_dist(wp_x[n-1], wp_y[n-1], rx, ry) < r2) begin
         res = '{wp_x[n-1], wp_y[n-1], 8'd0, SRC_END};
         return res;
      end
      near = 0;
      best = sq_dist(wp_x[0], wp_y[0], rx, ry);
      for (int i = 1; i < n; i++) begin
         d = sq_dist(wp_x[i], wp_y[i], rx, ry);
         if (d < best) begin
            best = d;
            near = i;
         end
      end
      for (int i = near + 1; i + 1 < n; i++) begin
         dc = sq_dist(wp_x[i], wp_y[i], rx, ry);
         dp = sq_dist(wp_x[i+1], wp_y[i+1], rx, ry);
         if (r2 < dc && dp < r2) begin
            // bisect from the inside point toward the outside one
            lo = 0;
            hi = T_ONE;
            nx = wp_x[i+1];
            ny = wp_y[i+1];
            for (int z = 0; z <= BISECT_LAST; z++) begin
               mid = (lo + hi) / 2;
               nx = along(wp_x[i+1], wp_x[i], mid);
               ny = along(wp_y[i+1], wp_y[i], mid);
               if (sq_dist(nx, ny, rx, ry) < r2) lo = mid;
               else hi = mid;
            end
            res = '{nx, ny, 8'(near), SRC_INTERP};
            return res;
         end
      end
      res = '{wp_x[near], wp_y[near], 8'(near), SRC_NEAREST};
      return res;
   endfunction

   assign pending = expected_points.size();

   always @(posedge clock) begin
      lookahead_type want;
      if (reset) begin
         wp_count = 0;
         radius = RADIUS_RESET;
         expected_points.delete();
         failures = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("unexpected response: point %0d,%0d", rsp_point_x, rsp_point_y);
               failures++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.px) begin
                  $error("point_x: expected %0d, actual %0d", want.px, rsp_point_x);
                  failures++;
               end
               if (rsp_point_y !== want.py) begin
                  $error("point_y: expected %0d, actual %0d", want.py, rsp_point_y);
                  failures++;
               end
               if (rsp_nearest_index !== want.idx) begin
                  $error("nearest_index: expected %0d, actual %0d", want.idx,
                         rsp_nearest_index);
                  failures++;
               end
               if (rsp_source !== want.src) begin
                  $error("source: expected %0d, actual %0d", want.src, rsp_source);
                  failures++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {CSR_RADIUS, 2'b00})
            radius = csr_pwdata[30:0];
         if (start && !busy) begin
            case (req_kind)
               KIND_CLEAR: wp_count = 0;
               KIND_APPEND: if (wp_count < PATH_DEPTH) begin
                  wp_x[wp_count] = req_pos_x;
                  wp_y[wp_count] = req_pos_y;
                  wp_count++;
               end
               KIND_QUERY: expected_points.push_back(find_point(req_pos_x, req_pos_y));
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
   import plpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int UNIT = 65536;   // 1.0 in Q16.16

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_kind;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic               rsp_valid;
   logic signed [31:0] rsp_point_x;
   logic signed [31:0] rsp_point_y;
   logic [7:0]         rsp_nearest_index;
   logic [1:0]         rsp_source;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 pending;
   int                 failures;

   // Requests counted toward the run length; ignored kinds do not count.
   int                 request_count;
   logic [30:0]        cur_radius;
   bit                 no_gaps;

   path_lookahead_point_finder_top dut (.*);
   path_lookahead_point_finder_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #60ms;
      $display("status: fail");
      $finish;
   end

   // Drive one request at the falling edge and hold it until the block takes it.
   task automatic send(logic [1:0] kind, logic signed [31:0] x, logic signed [31:0] y);
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_pos_x = x;
      req_pos_y = y;
      do @(posedge clock); while (busy);
      if (kind != KIND_UNUSED) request_count++;
   endtask

   // Drop start for a random gap: mostly none or short, now and then long.
   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return;
      n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Hold off until every expected response is in, plus the block's tail.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_radius(logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {CSR_RADIUS, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      cur_radius = value[30:0];
   endtask

   // Random offset of up to +/- span, wrapping into 32 bits.
   function automatic logic signed [31:0] jitter(logic signed [31:0] base, int unsigned span);
      return 32'(longint'(base) + longint'($urandom_range(0, 2 * span)) - longint'(span));
   endfunction

   initial begin
      logic signed [31:0] wx [$];
      logic signed [31:0] px, py;
      int unsigned span;
      int len, nq, sel;
      bit wide;

      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_CLEAR;
      req_pos_x = '0;
      req_pos_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      request_count = 0;
      cur_radius = RADIUS_RESET;
      no_gaps = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty path, ignored kind, end inside radius, nearest tie.
      send(KIND_QUERY, 32'sd5, -32'sd5);
      send(KIND_UNUSED, 32'sd1, 32'sd1);
      send(KIND_APPEND, 0, 0);
      send(KIND_APPEND, 20 * UNIT, 0);
      send(KIND_APPEND, 40 * UNIT, 0);
      send(KIND_QUERY, 45 * UNIT, 0);
      send(KIND_QUERY, 10 * UNIT, 0);
      // Path bends back so a later segment crosses into the circle.
      send(KIND_CLEAR, 0, 0);
      send(KIND_APPEND, 0, 0);
      send(KIND_APPEND, 30 * UNIT, 0);
      send(KIND_APPEND, 30 * UNIT, 30 * UNIT);
      send(KIND_APPEND, 5 * UNIT, 5 * UNIT);
      send(KIND_APPEND, 0, 40 * UNIT);
      send(KIND_QUERY, 0, 0);
      // End point exactly on the radius counts as outside.
      send(KIND_CLEAR, 0, 0);
      send(KIND_APPEND, 0, 0);
      send(KIND_APPEND, 12 * UNIT, 0);
      send(KIND_QUERY, 0, 0);
      // Coordinate extremes at the largest radius, then at zero radius.
      drain();
      write_radius(32'hFFFF_FFFF);
      send(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send(KIND_APPEND, 32'sh8000_0000, 32'sh8000_0000);
      send(KIND_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF);
      drain();
      write_radius(32'd0);
      send(KIND_QUERY, 32'sh8000_0000, 32'sh8000_0000);
      send(KIND_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000);

      // Random phases: build a path, then probe it with queries.
      while (request_count < 1000) begin
         if ($urandom_range(0, 5) == 0) begin
            drain();
            sel = $urandom_range(0, 9);
            case (sel)
               0: write_radius(32'd0);
               1: write_radius(32'h7FFF_FFFF);
               2: write_radius(32'hFFFF_FFFF);
               3: write_radius(RADIUS_RESET);
               4: write_radius($urandom());
               default: write_radius($urandom_range(UNIT, 40 * UNIT));
            endcase
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) != 0) begin
            send(KIND_CLEAR, $urandom(), $urandom());
            wx.delete();
         end
         idle_gap();
         // A few phases fill the store to near or past its depth; most keep paths short.
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 12);
         wide = ($urandom_range(0, 7) == 0);
         span = (cur_radius < 256) ? 256 : (cur_radius > 31'h3FFF_FFFF ? 32'h4000_0000
                                                                         : cur_radius);
         px = wide ? $urandom() : jitter(0, span);
         py = wide ? $urandom() : jitter(0, span);
         for (int k = 0; k < len; k++) begin
            send(KIND_APPEND, px, py);
            wx.push_back(px);
            idle_gap();
            px = wide ? $urandom() : jitter(px, span);
            py = wide ? $urandom() : jitter(py, span);
         end
         nq = $urandom_range(1, 6);
         for (int q = 0; q < nq; q++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) send(KIND_UNUSED, $urandom(), $urandom());
            else if (sel == 1) send(KIND_QUERY, $urandom(), $urandom());
            else send(KIND_QUERY, jitter(px, 2 * span), jitter(py, 2 * span));
            idle_gap();
         end
         if ($urandom_range(0, 7) == 0) drain();
      end

      drain();
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/plpf_pkg.sv
rtl/plpf_ram.sv
rtl/plpf_dist.sv
rtl/path_lookahead_point_finder_top.sv
tb/path_lookahead_point_finder_checker.sv
tb/testbench.sv
